[rtl/sgdl_pkg.sv]
`timescale 1ns / 1ps

package sgdl_pkg;

    // Fixed Q16.16 word and the widths that grow out of it.
    localparam int DATA_W = 32;
    localparam int FRAC   = 16;
    localparam int COST_W = 40;
    localparam int ACC_W  = 52;   // dot product of up to eight terms minus target
    localparam int SUM_W  = 56;   // sum of up to 64 squared error terms
    localparam int DIV_W  = 56;   // dividend width of the shift divider
    localparam int SH_W   = 3;    // shift amount up to log2(2*64)
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // Number of sample slots. It is a power of two, so both divisions by it are shifts.
    localparam int SAMPLES = 8;
    localparam logic [SH_W-1:0] COST_SH = SH_W'($clog2(2 * SAMPLES));
    localparam logic [SH_W-1:0] GRAD_SH = SH_W'($clog2(SAMPLES));

    // Stream payload widths, padded to whole bytes.
    localparam int IN_W  = 136;
    localparam int OUT_W = 216;

    localparam logic [DATA_W-1:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
    localparam logic [15:0]       RATE_RST = 16'd66;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_TRAIN = 1'b1;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [SH_W-1:0]   shift;
    } div_req_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = ACC_W'(-64'sd2147483648);
        if (v > hi)
            return 32'sh7FFF_FFFF;
        else if (v < lo)
            return 32'sh8000_0000;
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

[rtl/sgd_linear_regression_step.sv]
`timescale 1ns / 1ps
// A load item writes its sample slot and returns nothing. A train item returns one result; the
// next item is taken only after that result is placed in the output register, since tready is
// high only in the idle state.
// One shared multiplier forms every product; both divisions are shifts by constant amounts.
// A stalled result holds the block until the output register frees. rst_n is asynchronous,
// active low: weights clear, lowest cost goes to all ones, rate to 66; samples are kept.

module sgd_linear_regression_step #(
    parameter int FEATURES = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // tdata: sample_index[2:0], feature_one[34:3], feature_two[66:35],
    //        feature_three[98:67], target_value[130:99], zero pad above.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [sgdl_pkg::IN_W-1:0]   s_axis_tdata,
    // tuser: kind[0].
    input  logic                        s_axis_tuser,
    // tdata: step_cost[39:0], lowest_cost[79:40], new_best[80], best_bias[112:81],
    //        best_weight_one[144:113], best_weight_two[176:145],
    //        best_weight_three[208:177], zero pad above.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sgdl_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [15:0]                 cfg_data
);

    localparam int SAMPLES = sgdl_pkg::SAMPLES;
    localparam int AW    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int KW    = $clog2(FEATURES);
    localparam int ROW_W = sgdl_pkg::DATA_W * FEATURES;
    localparam int DW    = sgdl_pkg::DATA_W;
    localparam int AC    = sgdl_pkg::ACC_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_ERR   = 4'd4;
    localparam logic [3:0] ST_SQ    = 4'd5;
    localparam logic [3:0] ST_SQA   = 4'd6;
    localparam logic [3:0] ST_CDIV  = 4'd7;
    localparam logic [3:0] ST_CWAIT = 4'd8;
    localparam logic [3:0] ST_GRD   = 4'd9;
    localparam logic [3:0] ST_GM1   = 4'd10;
    localparam logic [3:0] ST_GM2   = 4'd11;
    localparam logic [3:0] ST_GM3   = 4'd12;
    localparam logic [3:0] ST_GM4   = 4'd13;
    localparam logic [3:0] ST_GW    = 4'd14;
    localparam logic [3:0] ST_OUT   = 4'd15;

    logic [3:0]                        state_reg;
    logic [3:0]                        state_next;
    logic [AW-1:0]                     samp_reg;
    logic [AW-1:0]                     tidx_reg;
    logic [KW-1:0]                     k_reg;
    logic signed [DW-1:0]              w_reg [FEATURES];
    logic signed [DW-1:0]              best_reg [FEATURES];
    logic [sgdl_pkg::COST_W-1:0]       lowest_reg;
    logic                              first_reg;
    logic [15:0]                       rate_reg;
    logic                              out_valid_reg;
    logic [sgdl_pkg::OUT_W-1:0]        out_data_reg;

    // Datapath registers, no reset.
    logic signed [AC-1:0]              acc_reg;
    logic signed [AC-1:0]              err_reg;
    logic [sgdl_pkg::SUM_W-1:0]        sum_reg;
    logic                              over_reg;
    logic signed [DW-1:0]              e_reg;
    logic [15:0]                       gl_reg;
    logic signed [AC-1:0]              hi_reg;
    logic                              neg_reg;
    logic [sgdl_pkg::COST_W-1:0]       cost_reg;
    logic                              newbest_reg;

    // Sample memory: slot 0 of a row is the target, slot k is feature k.
    logic                              in_range;
    logic                              accept;
    logic [AW-1:0]                     in_idx;
    logic                              ram_we;
    logic [ROW_W-1:0]                  ram_wdata;
    logic [ROW_W-1:0]                  row;

    logic signed [sgdl_pkg::MUL_W-1:0]  mul_a;
    logic signed [sgdl_pkg::MUL_W-1:0]  mul_b;
    logic signed [sgdl_pkg::PROD_W-1:0] prod;
    logic signed [sgdl_pkg::PROD_W-sgdl_pkg::FRAC-1:0] prod_sh;

    sgdl_pkg::div_req_t                div_req;
    logic                              div_done;
    logic [sgdl_pkg::DIV_W-1:0]        quotient;

    logic signed [DW-1:0]              xk;
    logic signed [DW-1:0]              target;
    logic signed [AC-1:0]              err_now;
    logic [AC-1:0]                     mag;
    logic                              big;
    logic signed [AC-1:0]              t_now;
    logic [AC-1:0]                     t_mag;
    logic signed [AC-1:0]              dq;
    logic signed [AC-1:0]              wdiff;
    logic [sgdl_pkg::COST_W-1:0]       cost_now;
    logic                              better;

    assign in_range      = 32'(s_axis_tdata[2:0]) < SAMPLES;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_idx        = AW'(s_axis_tdata[2:0]);
    assign ram_we        = accept && in_range && (s_axis_tuser == sgdl_pkg::KIND_LOAD);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        for (int k = 0; k < FEATURES; k++)
        begin
            case (k)
                0:       ram_wdata[k*DW +: DW] = s_axis_tdata[130:99];
                1:       ram_wdata[k*DW +: DW] = s_axis_tdata[34:3];
                2:       ram_wdata[k*DW +: DW] = s_axis_tdata[66:35];
                3:       ram_wdata[k*DW +: DW] = s_axis_tdata[98:67];
                default: ram_wdata[k*DW +: DW] = '0;
            endcase
        end
    end

    sgdl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SAMPLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_idx),
        .wdata (ram_wdata),
        .raddr (samp_reg),
        .rdata (row)
    );

    sgdl_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    sgdl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    // Feature k of the row being read; feature zero is the constant 1.0.
    assign xk      = (k_reg == '0) ? signed'(sgdl_pkg::ONE_Q16) : signed'(row[DW*k_reg +: DW]);
    assign target  = signed'(row[DW-1:0]);
    assign prod_sh = signed'(prod[sgdl_pkg::PROD_W-1:sgdl_pkg::FRAC]);
    assign err_now = acc_reg - AC'(target);
    assign mag     = err_reg[AC-1] ? AC'(-err_reg) : AC'(err_reg);
    assign big     = |mag[AC-1:DW];
    assign t_now   = hi_reg + AC'(prod_sh);
    assign t_mag   = t_now[AC-1] ? AC'(-t_now) : AC'(t_now);
    assign dq      = signed'(AC'(quotient));
    assign wdiff   = AC'(w_reg[k_reg]) - (neg_reg ? -dq : dq);

    always_comb
    begin
        if (over_reg || (|quotient[sgdl_pkg::DIV_W-1:sgdl_pkg::COST_W]))
            cost_now = sgdl_pkg::COST_MAX;
        else
            cost_now = quotient[sgdl_pkg::COST_W-1:0];
        better = !first_reg || (cost_now < lowest_reg);
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                mul_a = sgdl_pkg::MUL_W'(w_reg[k_reg]);
                mul_b = sgdl_pkg::MUL_W'(xk);
            end
            ST_SQ:
            begin
                mul_a = signed'({1'b0, mag[DW-1:0]});
                mul_b = signed'({1'b0, mag[DW-1:0]});
            end
            ST_GM1:
            begin
                mul_a = sgdl_pkg::MUL_W'(e_reg);
                mul_b = sgdl_pkg::MUL_W'(xk);
            end
            ST_GM2:
            begin
                // High part of the scaled gradient times the rate.
                mul_a = sgdl_pkg::MUL_W'(signed'(prod_sh[47:16]));
                mul_b = signed'({17'd0, rate_reg});
            end
            ST_GM3:
            begin
                mul_a = signed'({17'd0, gl_reg});
                mul_b = signed'({17'd0, rate_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_req = '0;
        if (state_reg == ST_CDIV)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_reg;
            div_req.shift    = sgdl_pkg::COST_SH;
        end
        else if (state_reg == ST_GM4)
        begin
            div_req.start    = 1'b1;
            div_req.dividend = sgdl_pkg::DIV_W'(t_mag);
            div_req.shift    = sgdl_pkg::GRAD_SH;
        end
    end

    // Sequencer: cost pass over all samples, cost division, best tracking, then one
    // gradient step per weight.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && in_range && (s_axis_tuser == sgdl_pkg::KIND_TRAIN))
                    state_next = ST_RD;
            ST_RD:    state_next = ST_MUL;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = (k_reg == KW'(FEATURES - 1)) ? ST_ERR : ST_MUL;
            ST_ERR:   state_next = ST_SQ;
            ST_SQ:    state_next = ST_SQA;
            ST_SQA:   state_next = (samp_reg == AW'(SAMPLES - 1)) ? ST_CDIV : ST_RD;
            ST_CDIV:  state_next = ST_CWAIT;
            ST_CWAIT: state_next = div_done ? ST_GRD : ST_CWAIT;
            ST_GRD:   state_next = ST_GM1;
            ST_GM1:   state_next = ST_GM2;
            ST_GM2:   state_next = ST_GM3;
            ST_GM3:   state_next = ST_GM4;
            ST_GM4:   state_next = ST_GW;
            ST_GW:
                if (div_done)
                    state_next = (k_reg == KW'(FEATURES - 1)) ? ST_OUT : ST_GM1;
            ST_OUT:
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            samp_reg      <= '0;
            tidx_reg      <= '0;
            k_reg         <= '0;
            lowest_reg    <= sgdl_pkg::COST_MAX;
            first_reg     <= 1'b0;
            rate_reg      <= sgdl_pkg::RATE_RST;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < FEATURES; k++)
            begin
                w_reg[k]    <= '0;
                best_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                rate_reg <= cfg_data;
            // The output register loads a new result when it is free or being emptied.
            if ((state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    samp_reg <= '0;
                    if (accept)
                        tidx_reg <= in_idx;
                end
                ST_RD:  k_reg <= '0;
                ST_ACC: k_reg <= (k_reg == KW'(FEATURES - 1)) ? '0 : k_reg + 1'b1;
                ST_SQA:
                    if (samp_reg != AW'(SAMPLES - 1))
                        samp_reg <= samp_reg + 1'b1;
                ST_CWAIT:
                    if (div_done)
                    begin
                        first_reg <= 1'b1;
                        samp_reg  <= tidx_reg;
                        if (better)
                        begin
                            lowest_reg <= cost_now;
                            for (int k = 0; k < FEATURES; k++)
                                best_reg[k] <= w_reg[k];
                        end
                    end
                ST_GRD: k_reg <= '0;
                ST_GW:
                    if (div_done)
                    begin
                        w_reg[k_reg] <= sgdl_pkg::sat32(wdiff);
                        k_reg        <= k_reg + 1'b1;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sum_reg  <= '0;
                over_reg <= 1'b0;
            end
            ST_RD:  acc_reg <= '0;
            ST_ACC: acc_reg <= acc_reg + AC'(prod_sh);
            ST_ERR:
            begin
                err_reg <= err_now;
                if (samp_reg == tidx_reg)
                    e_reg <= sgdl_pkg::sat32(err_now);
            end
            ST_SQA:
                if (big)
                    over_reg <= 1'b1;
                else
                    sum_reg <= sum_reg + sgdl_pkg::SUM_W'(prod[63:16]);
            ST_CWAIT:
                if (div_done)
                begin
                    cost_reg    <= cost_now;
                    newbest_reg <= better;
                end
            ST_GM2: gl_reg <= prod_sh[15:0];
            ST_GM3: hi_reg <= AC'(prod);
            ST_GM4: neg_reg <= t_now[AC-1];
            ST_OUT:
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_data_reg[39:0]  <= cost_reg;
                    out_data_reg[79:40] <= lowest_reg;
                    out_data_reg[80]    <= newbest_reg;
                    out_data_reg[sgdl_pkg::OUT_W-1:209] <= '0;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (k < FEATURES)
                            out_data_reg[81 + k*DW +: DW] <= best_reg[k % FEATURES];
                        else
                            out_data_reg[81 + k*DW +: DW] <= '0;
                    end
                end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[rtl/sgdl_ram.sv]
`timescale 1ns / 1ps

module sgdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sgdl_mul.sv]
`timescale 1ns / 1ps

module sgdl_mul (
    input  logic                                  clk,
    input  logic signed [sgdl_pkg::MUL_W-1:0]     a,
    input  logic signed [sgdl_pkg::MUL_W-1:0]     b,
    output logic signed [sgdl_pkg::PROD_W-1:0]    p
);

    // One signed product per cycle, registered.
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

[rtl/sgdl_div.sv]
`timescale 1ns / 1ps

module sgdl_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sgdl_pkg::div_req_t             req,
    output logic                           done,
    output logic [sgdl_pkg::DIV_W-1:0]     quotient
);

    logic                          done_reg;
    logic [sgdl_pkg::DIV_W-1:0]    quo_reg;

    // Division by a power of two: the quotient is the dividend shifted right,
    // ready in the cycle after start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend >> req.shift;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/sgdl_checker.sv]
`timescale 1ns / 1ps

module sgdl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [sgdl_pkg::IN_W-1:0]   s_axis_tdata,
    input logic                        s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [sgdl_pkg::OUT_W-1:0]  m_axis_tdata,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [15:0]                 cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_lowest_le_cost: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[79:40] <= m_axis_tdata[39:0])
        else $error("lowest cost above step cost");

    a_best_equal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[80] |-> m_axis_tdata[79:40] == m_axis_tdata[39:0])
        else $error("new best without matching lowest cost");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == sgdl_pkg::KIND_LOAD)
        && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("load item produced a result");

endmodule

bind sgd_linear_regression_step sgdl_checker u_sgdl_checker (.*);
